### sv/modular_arith_unit_top_macros.svh
`ifndef MODULAR_ARITH_UNIT_TOP_MACROS_SVH
`define MODULAR_ARITH_UNIT_TOP_MACROS_SVH

// same-cycle implication, sampled on the block clock, off during reset
`define MAU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MAU_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/mau_pkg.sv
`default_nettype none

package mau_pkg;

    localparam int unsigned MOD_W = 16;
    localparam int unsigned OPD_W = 32;

    localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(251);
    localparam logic [MOD_W-1:0] MOD_MIN   = MOD_W'(2);

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED,
        ST_INV,
        ST_MUL,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_op              operation;
        logic [OPD_W-1:0] operand_a;
        logic [OPD_W-1:0] operand_b;
    } t_in_beat;

    typedef struct packed {
        logic [MOD_W-1:0] result;
        logic             no_inverse;
    } t_out_beat;

    typedef struct packed {
        logic             done;
        logic             ok;
        logic [MOD_W-1:0] inv;
    } t_inv_status;

    // x + y mod m, both inputs already below m
    function automatic logic [MOD_W-1:0] add_mod(
        input logic [MOD_W-1:0] x,
        input logic [MOD_W-1:0] y,
        input logic [MOD_W-1:0] m
    );
        logic [MOD_W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[MOD_W-1:0];
    endfunction

    // x - y mod m, both inputs already below m
    function automatic logic [MOD_W-1:0] sub_mod(
        input logic [MOD_W-1:0] x,
        input logic [MOD_W-1:0] y,
        input logic [MOD_W-1:0] m
    );
        logic [MOD_W:0] s;
        if (x >= y) begin
            s = {1'b0, x} - {1'b0, y};
        end else begin
            s = {1'b0, x} + {1'b0, m} - {1'b0, y};
        end
        return s[MOD_W-1:0];
    endfunction

endpackage

`default_nettype wire

### sv/mau_reduce.sv
`default_nettype none

// bit-serial remainder of a wide operand, msb first, one bit per cycle
module mau_reduce (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [mau_pkg::OPD_W-1:0] i_value,
    input  wire logic [mau_pkg::MOD_W-1:0] i_mod,
    output logic                           o_done,
    output logic [mau_pkg::MOD_W-1:0]      o_rem
);

    localparam int unsigned CNT_W = $clog2(mau_pkg::OPD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(mau_pkg::OPD_W - 1);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [mau_pkg::OPD_W-1:0] r_shift;
    logic [mau_pkg::MOD_W-1:0] r_rem;

    logic [mau_pkg::MOD_W:0]   n_part;
    logic [mau_pkg::MOD_W-1:0] n_rem;

    always_comb begin
        n_part = {r_rem, r_shift[mau_pkg::OPD_W-1]};
        if (n_part >= {1'b0, i_mod}) begin
            n_part = n_part - {1'b0, i_mod};
        end
        n_rem = n_part[mau_pkg::MOD_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_shift <= i_value;
            r_rem   <= '0;
        end else if (r_busy) begin
            r_shift <= {r_shift[mau_pkg::OPD_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

### sv/mau_mulmod.sv
`default_nettype none

// interleaved modular multiply, one multiplier bit per cycle, msb first
module mau_mulmod (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [mau_pkg::MOD_W-1:0] i_x,
    input  wire logic [mau_pkg::MOD_W-1:0] i_y,
    input  wire logic [mau_pkg::MOD_W-1:0] i_mod,
    output logic                           o_done,
    output logic [mau_pkg::MOD_W-1:0]      o_prod
);

    localparam int unsigned CNT_W = $clog2(mau_pkg::MOD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(mau_pkg::MOD_W - 1);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [mau_pkg::MOD_W-1:0] r_x;
    logic [mau_pkg::MOD_W-1:0] r_y;
    logic [mau_pkg::MOD_W-1:0] r_acc;

    logic [mau_pkg::MOD_W-1:0] n_dbl;
    logic [mau_pkg::MOD_W-1:0] n_acc;

    always_comb begin
        n_dbl = mau_pkg::add_mod(r_acc, r_acc, i_mod);
        n_acc = r_y[mau_pkg::MOD_W-1] ? mau_pkg::add_mod(n_dbl, r_x, i_mod) : n_dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_acc <= '0;
        end else if (r_busy) begin
            r_y   <= {r_y[mau_pkg::MOD_W-2:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

### sv/mau_inverse.sv
`default_nettype none

// shift-subtract euclid; cofactors kept mod m so r == t * b (mod m) always holds
module mau_inverse (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [mau_pkg::MOD_W-1:0] i_b,
    input  wire logic [mau_pkg::MOD_W-1:0] i_mod,
    output mau_pkg::t_inv_status           o_status
);

    logic                      r_busy;
    logic [mau_pkg::MOD_W-1:0] r_r0;
    logic [mau_pkg::MOD_W-1:0] r_r1;
    logic [mau_pkg::MOD_W-1:0] r_t0;
    logic [mau_pkg::MOD_W-1:0] r_t1;
    logic [mau_pkg::MOD_W-1:0] r_d;
    logic [mau_pkg::MOD_W-1:0] r_td;

    logic                      fin;
    logic                      can_dbl;

    assign fin     = (r_r1 == '0);
    assign can_dbl = ({r_d, 1'b0} <= {1'b0, r_r0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && fin) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_r0 <= i_mod;
            r_r1 <= i_b;
            r_t0 <= '0;
            r_t1 <= mau_pkg::MOD_W'(1);
            r_d  <= i_b;
            r_td <= mau_pkg::MOD_W'(1);
        end else if (r_busy && !fin) begin
            if (r_r0 < r_r1) begin
                // swap roles, realign from the new smaller remainder
                r_r0 <= r_r1;
                r_r1 <= r_r0;
                r_t0 <= r_t1;
                r_t1 <= r_t0;
                r_d  <= r_r0;
                r_td <= r_t0;
            end else if (can_dbl) begin
                r_d  <= {r_d[mau_pkg::MOD_W-2:0], 1'b0};
                r_td <= mau_pkg::add_mod(r_td, r_td, i_mod);
            end else begin
                r_r0 <= r_r0 - r_d;
                r_t0 <= mau_pkg::sub_mod(r_t0, r_td, i_mod);
                r_d  <= r_r1;
                r_td <= r_t1;
            end
        end
    end

    assign o_status.done = r_busy && fin;
    assign o_status.ok   = (r_r0 == mau_pkg::MOD_W'(1));
    assign o_status.inv  = r_t0;

endmodule

`default_nettype wire

### sv/modular_arith_unit_top.sv
// channel | valid      | stall       | payload
// input   | i_in_valid | o_in_stall  | i_in_data  (mau_pkg::t_in_beat)
// output  | o_out_valid| i_out_stall | o_out_data (mau_pkg::t_out_beat)
// config  | i_cfg_we   | -           | i_cfg_data (modulus)
//
// one item at a time; both operands are reduced bit-serially. add and subtract then
// finish combinationally, multiply runs the bit-serial multiplier; divide first runs
// euclid steps, each a doubling, subtract or swap (none for a zero divisor), and then
// multiplies by the inverse, or returns zero with no_inverse set when there is none.
// synchronous active-low reset; modulus resets to 251, a value below 2 acts as 2.
// input stalls until the result moves to the output register, where it may wait.
`default_nettype none

module modular_arith_unit_top (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire mau_pkg::t_in_beat         i_in_data,
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output mau_pkg::t_out_beat             o_out_data,
    input  wire logic                      i_cfg_we,
    input  wire logic [mau_pkg::MOD_W-1:0] i_cfg_data
);

    mau_pkg::t_state           r_state;
    mau_pkg::t_state           n_state;
    mau_pkg::t_op              r_op;
    logic [mau_pkg::MOD_W-1:0] r_mod;
    logic [mau_pkg::MOD_W-1:0] r_res;
    logic [mau_pkg::MOD_W-1:0] n_res;
    logic                      r_flag;
    logic                      n_flag;
    logic                      r_out_vld;
    mau_pkg::t_out_beat        r_out;

    logic [mau_pkg::MOD_W-1:0] m_eff;
    logic                      in_acc;
    logic                      out_load;
    logic                      red_done_a;
    logic                      red_done_b;
    logic [mau_pkg::MOD_W-1:0] red_a;
    logic [mau_pkg::MOD_W-1:0] red_b;
    logic                      mul_start;
    logic [mau_pkg::MOD_W-1:0] mul_y;
    logic                      mul_done;
    logic [mau_pkg::MOD_W-1:0] mul_prod;
    logic                      inv_start;
    mau_pkg::t_inv_status      inv_st;

    assign m_eff  = (r_mod < mau_pkg::MOD_MIN) ? mau_pkg::MOD_MIN : r_mod;
    assign in_acc = i_in_valid && (r_state == mau_pkg::ST_IDLE);

    mau_reduce u_red_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_value (i_in_data.operand_a),
        .i_mod   (m_eff),
        .o_done  (red_done_a),
        .o_rem   (red_a)
    );

    mau_reduce u_red_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_value (i_in_data.operand_b),
        .i_mod   (m_eff),
        .o_done  (red_done_b),
        .o_rem   (red_b)
    );

    mau_inverse u_inv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (inv_start),
        .i_b      (red_b),
        .i_mod    (m_eff),
        .o_status (inv_st)
    );

    mau_mulmod u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_x     (red_a),
        .i_y     (mul_y),
        .i_mod   (m_eff),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mau_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_res     = r_res;
        n_flag    = r_flag;
        mul_start = 1'b0;
        mul_y     = red_b;
        inv_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            mau_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_state = mau_pkg::ST_RED;
                end
            end
            mau_pkg::ST_RED: begin
                if (red_done_a && red_done_b) begin
                    n_flag = 1'b0;
                    case (r_op)
                        mau_pkg::OP_ADD: begin
                            n_res   = mau_pkg::add_mod(red_a, red_b, m_eff);
                            n_state = mau_pkg::ST_DONE;
                        end
                        mau_pkg::OP_SUB: begin
                            n_res   = mau_pkg::sub_mod(red_a, red_b, m_eff);
                            n_state = mau_pkg::ST_DONE;
                        end
                        mau_pkg::OP_MUL: begin
                            mul_start = 1'b1;
                            n_state   = mau_pkg::ST_MUL;
                        end
                        mau_pkg::OP_DIV: begin
                            inv_start = 1'b1;
                            n_state   = mau_pkg::ST_INV;
                        end
                        default: begin
                            n_state = mau_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            mau_pkg::ST_INV: begin
                if (inv_st.done) begin
                    if (inv_st.ok) begin
                        mul_start = 1'b1;
                        mul_y     = inv_st.inv;
                        n_state   = mau_pkg::ST_MUL;
                    end else begin
                        n_res   = '0;
                        n_flag  = 1'b1;
                        n_state = mau_pkg::ST_DONE;
                    end
                end
            end
            mau_pkg::ST_MUL: begin
                if (mul_done) begin
                    n_res   = mul_prod;
                    n_state = mau_pkg::ST_DONE;
                end
            end
            mau_pkg::ST_DONE: begin
                // output register free, or its beat leaves at this edge
                if (!r_out_vld || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = mau_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mau_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod     <= mau_pkg::MOD_RESET;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mod <= i_cfg_data;
            end
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res  <= n_res;
        r_flag <= n_flag;
        if (in_acc) begin
            r_op <= i_in_data.operation;
        end
        if (out_load) begin
            r_out.result     <= r_res;
            r_out.no_inverse <= r_flag;
        end
    end

    assign o_in_stall  = (r_state != mau_pkg::ST_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### sv/mau_checker.sv
`include "modular_arith_unit_top_macros.svh"
`default_nettype none

module mau_checker (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire mau_pkg::t_out_beat o_out_data
);

    `MAU_ASSERT_NXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_data), "stalled output beat changed or dropped")

    `MAU_ASSERT_NOW(a_noinv_zero, o_out_valid && o_out_data.no_inverse, o_out_data.result == '0, "no_inverse beat with nonzero result")

    `MAU_ASSERT_NXT(a_one_item, i_in_valid && !o_in_stall, o_in_stall, "input taken again while an item is in flight")

    `MAU_ASSERT_NXT(a_no_early_out, i_in_valid && !o_in_stall, !$rose(o_out_valid), "result beat appeared right after input beat")

endmodule

bind modular_arith_unit_top mau_checker u_mau_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
